>>> hdl/tlg_pkg.sv
// tlg_pkg: shared constants, codes and types for the toroidal life block.
// No dependencies.
package tlg_pkg;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 32;

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLS);

   // Both grids live in one row-wide RAM, grid select is the address MSB.
   localparam int RAM_AW    = ROW_W + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;

   localparam int ACTION_W = 2;
   localparam int FIELD_W  = 5;
   localparam int GEN_W    = 16;

   localparam int NBR_CNT_W     = 4;
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CELL,
      ST_LOAD,
      ST_CELLS,
      ST_STORE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/tlg_req_if.sv
// tlg_req_if: request channel (valid/ready plus cell command payload).
// Depends on tlg_pkg.
interface tlg_req_if;
   logic                          valid;
   logic                          ready;
   logic [tlg_pkg::ACTION_W-1:0]  action;
   logic [tlg_pkg::FIELD_W-1:0]   row;
   logic [tlg_pkg::FIELD_W-1:0]   col;
   logic                          alive;

   modport source (output valid, output action, output row, output col, output alive,
                   input ready);
   modport sink   (input valid, input action, input row, input col, input alive,
                   output ready);
endinterface

>>> hdl/tlg_rsp_if.sv
// tlg_rsp_if: response channel (valid/ready plus cell value and generation).
// Depends on tlg_pkg.
interface tlg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       cell_value;
   logic [tlg_pkg::GEN_W-1:0]  generation;

   modport source (output valid, output cell_value, output generation, input ready);
   modport sink   (input valid, input cell_value, input generation, output ready);
endinterface

>>> hdl/tlg_ram.sv
// tlg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlg_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/tlg_rule.sv
// tlg_rule: shared life rule unit, one cell per cycle from its 3x3 window.
// Depends on tlg_pkg.
module tlg_rule (
   input  logic       self_alive,
   input  logic [7:0] nbrs,
   output logic       next_alive
);
   logic [tlg_pkg::NBR_CNT_W-1:0] count;

   always_comb begin
      count = '0;
      for (int i = 0; i < 8; i++) begin
         count = count + tlg_pkg::NBR_CNT_W'(nbrs[i]);
      end
      next_alive = (count == tlg_pkg::NBR_CNT_W'(tlg_pkg::BIRTH_COUNT)) ||
                   (self_alive && (count == tlg_pkg::NBR_CNT_W'(tlg_pkg::SURVIVE_COUNT)));
   end
endmodule

>>> hdl/toroidal_life_generation.sv
// Toroidal life engine: read/write runs through ST_CELL and ST_FINISH, which
// registers the response; no new request is taken until the block is idle again.
// Step: ST_LOAD fetches the last row, row 0 and row 1 into the window, then
// one cell per cycle through the shared rule unit, plus ST_STORE and ST_SHIFT
// per row, then ST_FINISH. One request in flight; ready only while idle, and a
// finished request waits while the previous response is still unaccepted.
// Reset (synchronous): clears control state, then sweeps all 2**(ROW_W+1) rows
// of the row RAM (64 for 32 rows) to zero before the first request is taken.
// Depends on tlg_pkg, tlg_req_if, tlg_rsp_if, tlg_ram, tlg_rule.
module toroidal_life_generation (
   input  logic       clock,
   input  logic       reset,
   tlg_req_if.sink    req_bus,
   tlg_rsp_if.source  rsp_bus
);
   localparam int ROW_W  = tlg_pkg::ROW_W;
   localparam int COL_W  = tlg_pkg::COL_W;
   localparam int COLS   = tlg_pkg::GRID_COLS;
   localparam int RAM_AW = tlg_pkg::RAM_AW;
   localparam int GEN_W  = tlg_pkg::GEN_W;

   // control state
   tlg_pkg::state_type state_ff, state_in;
   logic [RAM_AW-1:0]  clear_addr_ff, clear_addr_in;
   logic               sel_ff, sel_in;          // current grid
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [tlg_pkg::ACTION_W-1:0] action_ff, action_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               alive_ff, alive_in;
   logic               inside_ff, inside_in;
   logic               value_ff, value_in;
   logic [ROW_W-1:0]   row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0]   col_cnt_ff, col_cnt_in;
   logic [1:0]         load_cnt_ff, load_cnt_in;
   logic [COLS-1:0]    up_ff, up_in, mid_ff, mid_in, dn_ff, dn_in, nxt_ff, nxt_in;
   logic               rsp_cell_ff, rsp_cell_in;
   logic [GEN_W-1:0]   rsp_gen_ff, rsp_gen_in;

   // RAM port
   logic               wr_en;
   logic [RAM_AW-1:0]  wr_addr;
   logic [COLS-1:0]    wr_data;
   logic [RAM_AW-1:0]  rd_addr;
   logic [COLS-1:0]    rd_data;

   // cell window
   logic [COL_W-1:0]   lf, rt;
   logic [7:0]         nbrs;
   logic               self_alive;
   logic               rule_next;
   logic [ROW_W:0]     row_plus2;
   logic [COLS-1:0]    merged;
   logic               req_inside;

   tlg_ram #(
      .WIDTH (COLS),
      .DEPTH (tlg_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tlg_rule u_rule (
      .self_alive (self_alive),
      .nbrs       (nbrs),
      .next_alive (rule_next)
   );

   // neighborhood wraps at both column edges; rows wrap via up/dn row fetch
   always_comb begin
      lf = (col_cnt_ff == '0) ? COL_W'(COLS - 1) : col_cnt_ff - COL_W'(1);
      rt = (col_cnt_ff == COL_W'(COLS - 1)) ? '0 : col_cnt_ff + COL_W'(1);
      nbrs = {up_ff[lf], up_ff[col_cnt_ff], up_ff[rt],
              mid_ff[lf], mid_ff[rt],
              dn_ff[lf], dn_ff[col_cnt_ff], dn_ff[rt]};
      self_alive = mid_ff[col_cnt_ff];
   end

   // row to fetch as the new bottom row after storing row_cnt
   always_comb begin
      row_plus2 = {1'b0, row_cnt_ff} + (ROW_W + 1)'(2);
      if (row_plus2 >= (ROW_W + 1)'(tlg_pkg::GRID_ROWS)) begin
         row_plus2 = row_plus2 - (ROW_W + 1)'(tlg_pkg::GRID_ROWS);
      end
   end

   assign req_inside = (32'(req_bus.row) < tlg_pkg::GRID_ROWS) &&
                       (32'(req_bus.col) < tlg_pkg::GRID_COLS);

   // cell write: patch one bit into the fetched row
   always_comb begin
      merged = rd_data;
      merged[col_ff] = alive_ff;
   end

   // sequencer: next state, register next values, RAM control
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      sel_in        = sel_ff;
      gen_in        = gen_ff;
      action_in     = action_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      alive_in      = alive_ff;
      inside_in     = inside_ff;
      value_in      = value_ff;
      row_cnt_in    = row_cnt_ff;
      col_cnt_in    = col_cnt_ff;
      load_cnt_in   = load_cnt_ff;
      up_in         = up_ff;
      mid_in        = mid_ff;
      dn_in         = dn_ff;
      nxt_in        = nxt_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      req_bus.ready = 1'b0;
      wr_en   = 1'b0;
      wr_addr = {sel_ff, row_ff};
      wr_data = merged;
      rd_addr = {sel_ff, row_cnt_ff};

      case (state_ff)
         tlg_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_ff;
            wr_data = '0;
            clear_addr_in = clear_addr_ff + RAM_AW'(1);
            if (clear_addr_ff == RAM_AW'(tlg_pkg::RAM_DEPTH - 1)) begin
               state_in = tlg_pkg::ST_IDLE;
            end
         end
         tlg_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            rd_addr = {sel_ff, ROW_W'(req_bus.row)};
            if (req_bus.valid) begin
               action_in = req_bus.action;
               row_in    = ROW_W'(req_bus.row);
               col_in    = COL_W'(req_bus.col);
               alive_in  = req_bus.alive;
               inside_in = req_inside;
               value_in  = 1'b0;
               case (req_bus.action)
                  tlg_pkg::ACT_WRITE,
                  tlg_pkg::ACT_READ: begin
                     state_in = tlg_pkg::ST_CELL;
                  end
                  tlg_pkg::ACT_STEP: begin
                     load_cnt_in = '0;
                     row_cnt_in  = '0;
                     state_in    = tlg_pkg::ST_LOAD;
                  end
                  default: begin
                     state_in = tlg_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         tlg_pkg::ST_CELL: begin
            // fetched row of the addressed cell is on rd_data
            if (action_ff == tlg_pkg::ACT_READ) begin
               value_in = inside_ff && rd_data[col_ff];
            end else begin
               wr_en = inside_ff;
            end
            state_in = tlg_pkg::ST_FINISH;
         end
         tlg_pkg::ST_LOAD: begin
            // fetch last row, row 0, row 1; shift each into the window
            case (load_cnt_ff)
               2'd0:    rd_addr = {sel_ff, ROW_W'(tlg_pkg::GRID_ROWS - 1)};
               2'd1:    rd_addr = {sel_ff, ROW_W'(0)};
               default: rd_addr = {sel_ff, ROW_W'(1)};
            endcase
            if (load_cnt_ff != 2'd0) begin
               up_in  = mid_ff;
               mid_in = dn_ff;
               dn_in  = rd_data;
            end
            load_cnt_in = load_cnt_ff + 2'd1;
            if (load_cnt_ff == 2'd3) begin
               col_cnt_in = '0;
               state_in   = tlg_pkg::ST_CELLS;
            end
         end
         tlg_pkg::ST_CELLS: begin
            nxt_in[col_cnt_ff] = rule_next;
            col_cnt_in = col_cnt_ff + COL_W'(1);
            if (col_cnt_ff == COL_W'(COLS - 1)) begin
               state_in = tlg_pkg::ST_STORE;
            end
         end
         tlg_pkg::ST_STORE: begin
            // finished row goes to the other grid; fetch next bottom row
            wr_en   = 1'b1;
            wr_addr = {!sel_ff, row_cnt_ff};
            wr_data = nxt_ff;
            rd_addr = {sel_ff, row_plus2[ROW_W-1:0]};
            state_in = tlg_pkg::ST_SHIFT;
         end
         tlg_pkg::ST_SHIFT: begin
            up_in  = mid_ff;
            mid_in = dn_ff;
            dn_in  = rd_data;
            col_cnt_in = '0;
            if (row_cnt_ff == ROW_W'(tlg_pkg::GRID_ROWS - 1)) begin
               sel_in   = !sel_ff;
               gen_in   = gen_ff + GEN_W'(1);
               state_in = tlg_pkg::ST_FINISH;
            end else begin
               row_cnt_in = row_cnt_ff + ROW_W'(1);
               state_in   = tlg_pkg::ST_CELLS;
            end
         end
         tlg_pkg::ST_FINISH: begin
            // hold until the response slot is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = value_ff;
               rsp_gen_in   = gen_ff;
               state_in     = tlg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlg_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         sel_ff        <= 1'b0;
         gen_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         sel_ff        <= sel_in;
         gen_ff        <= gen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      alive_ff    <= alive_in;
      inside_ff   <= inside_in;
      value_ff    <= value_in;
      row_cnt_ff  <= row_cnt_in;
      col_cnt_ff  <= col_cnt_in;
      load_cnt_ff <= load_cnt_in;
      up_ff       <= up_in;
      mid_ff      <= mid_in;
      dn_ff       <= dn_in;
      nxt_ff      <= nxt_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_gen_ff  <= rsp_gen_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cell_value = rsp_cell_ff;
   assign rsp_bus.generation = rsp_gen_ff;
endmodule

>>> sim/toroidal_life_generation_tb.sv
`timescale 1ns / 1ps
// toroidal_life_generation_tb: self-checking bench for the toroidal life engine.
// Needs tlg_pkg, tlg_req_if, tlg_rsp_if and the toroidal_life_generation RTL.
module toroidal_life_generation_tb;

   typedef logic [tlg_pkg::ACTION_W-1:0] action_type;
   typedef logic [tlg_pkg::FIELD_W-1:0]  field_type;

   // Unassigned action code: the block must leave all state alone.
   localparam action_type ACT_UNUSED = 2'd3;

   // Longest legal quiet spell is one step plus the post-reset RAM sweep
   // and a few stalls; allow many times that.
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int IDLE_PCT       = 26;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic                      cell_value;
      logic [tlg_pkg::GEN_W-1:0] generation;
   } life_response_type;

   logic clock;
   logic reset;

   tlg_req_if req_bus ();
   tlg_rsp_if rsp_bus ();

   toroidal_life_generation u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // Mirror of the block state: both grids, the current-grid pointer and
   // the generation counter. Everything starts dead, grid 0 current.
   // ---------------------------------------------------------------------
   bit                        life_cells [2][tlg_pkg::GRID_ROWS][tlg_pkg::GRID_COLS];
   bit                        cur_grid;
   logic [tlg_pkg::GEN_W-1:0] gen_count;

   life_response_type pending_responses [$];

   // Steady stretch: while set, neither side inserts bubbles.
   bit steady;

   int mismatches;
   int responses_checked;
   int writes_sent;
   int reads_sent;
   int steps_sent;
   int unused_sent;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the mirror and return the response it must give.
   function automatic life_response_type predict_life_response(
      input action_type action,
      input field_type  row,
      input field_type  col,
      input logic       alive
   );
      life_response_type res;
      bit                in_grid;
      int                r, c, dr, dc, nbrs;
      res.cell_value = 1'b0;
      in_grid = (int'(row) < tlg_pkg::GRID_ROWS) && (int'(col) < tlg_pkg::GRID_COLS);
      case (action)
         tlg_pkg::ACT_WRITE: begin
            if (in_grid) life_cells[cur_grid][row][col] = alive;
         end
         tlg_pkg::ACT_READ: begin
            if (in_grid) res.cell_value = life_cells[cur_grid][row][col];
         end
         tlg_pkg::ACT_STEP: begin
            // Next generation goes to the other grid; neighbours wrap both ways.
            for (r = 0; r < tlg_pkg::GRID_ROWS; r++) begin
               for (c = 0; c < tlg_pkg::GRID_COLS; c++) begin
                  nbrs = 0;
                  for (dr = -1; dr <= 1; dr++) begin
                     for (dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0)
                           nbrs += life_cells[cur_grid]
                                      [(r + dr + tlg_pkg::GRID_ROWS) % tlg_pkg::GRID_ROWS]
                                      [(c + dc + tlg_pkg::GRID_COLS) % tlg_pkg::GRID_COLS];
                     end
                  end
                  if (life_cells[cur_grid][r][c])
                     life_cells[~cur_grid][r][c] = (nbrs == tlg_pkg::SURVIVE_COUNT) ||
                                                   (nbrs == tlg_pkg::BIRTH_COUNT);
                  else
                     life_cells[~cur_grid][r][c] = (nbrs == tlg_pkg::BIRTH_COUNT);
               end
            end
            cur_grid  = ~cur_grid;
            gen_count = gen_count + 1'b1;  // wraps at 16 bits
         end
         default: ;  // unused code: nothing changes
      endcase
      res.generation = gen_count;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%t ERROR %s", $realtime, msg);
   endtask

   // Drive one request, hold it until accepted, then log its expectation.
   // Valid is left high on exit; an idle bubble before the next request or a drain lowers it.
   task automatic send_request(
      input action_type action,
      input field_type  row,
      input field_type  col,
      input logic       alive
   );
      bit taken;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.action <= action;
      req_bus.row    <= row;
      req_bus.col    <= col;
      req_bus.alive  <= alive;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
      end
      pending_responses.push_back(predict_life_response(action, row, col, alive));
      case (action)
         tlg_pkg::ACT_WRITE: writes_sent++;
         tlg_pkg::ACT_READ:  reads_sent++;
         tlg_pkg::ACT_STEP:  steps_sent++;
         default:            unused_sent++;
      endcase
   endtask

   // Stop sending and wait until every outstanding response is back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, then field-by-field compare
   // against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : check_responses
      life_response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: cell=%0b gen=%0d",
                                      rsp_bus.cell_value, rsp_bus.generation));
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            if (rsp_bus.cell_value !== want.cell_value)
               report_mismatch($sformatf("cell_value exp %0b got %0b",
                                         want.cell_value, rsp_bus.cell_value));
            if (rsp_bus.generation !== want.generation)
               report_mismatch($sformatf("generation exp %0d got %0d",
                                         want.generation, rsp_bus.generation));
         end
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%t ERROR no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("FAIL toroidal_life_generation");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed: corner cells, both write values, reads, unused action code.
   // ---------------------------------------------------------------------
   task automatic test_cell_access();
      send_request(tlg_pkg::ACT_WRITE, 5'd0,  5'd0,  1'b1);
      send_request(tlg_pkg::ACT_WRITE, 5'd0,  5'd31, 1'b1);
      send_request(tlg_pkg::ACT_WRITE, 5'd31, 5'd0,  1'b1);
      send_request(tlg_pkg::ACT_WRITE, 5'd31, 5'd31, 1'b1);
      send_request(tlg_pkg::ACT_READ,  5'd0,  5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd0,  5'd31, 1'b1);
      send_request(tlg_pkg::ACT_READ,  5'd31, 5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd31, 5'd31, 1'b1);
      // Clear a cell again, then make sure it reads dead.
      send_request(tlg_pkg::ACT_WRITE, 5'd0,  5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd0,  5'd0,  1'b1);
      // Unused code aimed at (31,30) must not write that cell nor step.
      send_request(ACT_UNUSED,         5'd31, 5'd30, 1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd31, 5'd30, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Directed: two blinkers that straddle the row and column seams, so
   // the neighbour count only works if the grid really wraps.
   // ---------------------------------------------------------------------
   task automatic test_edge_wrap();
      // Vertical blinker on column 31 through rows 31, 0, 1.
      send_request(tlg_pkg::ACT_WRITE, 5'd31, 5'd0,  1'b0);
      send_request(tlg_pkg::ACT_WRITE, 5'd1,  5'd31, 1'b1);
      // Horizontal blinker on row 16 through columns 31, 0, 1.
      send_request(tlg_pkg::ACT_WRITE, 5'd16, 5'd31, 1'b1);
      send_request(tlg_pkg::ACT_WRITE, 5'd16, 5'd0,  1'b1);
      send_request(tlg_pkg::ACT_WRITE, 5'd16, 5'd1,  1'b1);
      send_request(tlg_pkg::ACT_STEP,  5'd0,  5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd0,  5'd30, 1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd0,  5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd31, 5'd31, 1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd15, 5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd17, 5'd0,  1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd16, 5'd1,  1'b0);
      // Second step flips both back.
      send_request(tlg_pkg::ACT_STEP,  5'd31, 5'd31, 1'b1);
      send_request(tlg_pkg::ACT_READ,  5'd1,  5'd31, 1'b0);
      send_request(tlg_pkg::ACT_READ,  5'd16, 5'd31, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Random: mostly seed-a-patch / step / probe bursts at random places
   // (patches wrap across the seams through 5-bit address overflow),
   // with some unstructured noise bursts mixed in.
   // ---------------------------------------------------------------------
   task automatic test_random_traffic(input int item_budget, input bit with_steady);
      field_type base_r, base_c;
      int        first, burst, i, count;
      first = writes_sent + reads_sent + steps_sent + unused_sent;
      burst = 0;
      while (writes_sent + reads_sent + steps_sent + unused_sent - first < item_budget) begin
         steady = with_steady && (burst >= 3) && (burst < 11);
         if ($urandom_range(99) < 80) begin
            base_r = field_type'($urandom);
            base_c = field_type'($urandom);
            count  = $urandom_range(4, 12);
            for (i = 0; i < count; i++)
               send_request(tlg_pkg::ACT_WRITE,
                            field_type'(base_r + $urandom_range(0, 4)),
                            field_type'(base_c + $urandom_range(0, 4)),
                            $urandom_range(99) < 45);
            count = $urandom_range(1, 2);
            for (i = 0; i < count; i++)
               send_request(tlg_pkg::ACT_STEP, field_type'($urandom),
                            field_type'($urandom), 1'($urandom));
            // Probe the patch and its rim, where births and deaths happen.
            count = $urandom_range(3, 8);
            for (i = 0; i < count; i++)
               send_request(tlg_pkg::ACT_READ,
                            field_type'(base_r + $urandom_range(0, 6) - 1),
                            field_type'(base_c + $urandom_range(0, 6) - 1),
                            1'($urandom));
         end else begin
            count = $urandom_range(3, 6);
            for (i = 0; i < count; i++)
               send_request(action_type'($urandom_range(0, 3)), field_type'($urandom),
                            field_type'($urandom), 1'($urandom));
         end
         burst++;
      end
      steady = 1'b0;
   endtask

   // Sender goes silent until the pipe is empty, then resumes with reads
   // of the settled grid and one more step.
   task automatic test_drain_pause();
      int i;
      wait_for_drain();
      for (i = 0; i < 4; i++)
         send_request(tlg_pkg::ACT_READ, field_type'($urandom), field_type'($urandom),
                      1'($urandom));
      send_request(tlg_pkg::ACT_STEP, field_type'($urandom), field_type'($urandom),
                   1'($urandom));
   endtask

   initial begin
      reset          = 1'b1;
      steady         = 1'b0;
      cur_grid       = 1'b0;
      gen_count      = '0;
      quiet_cycles   = 0;
      req_bus.valid  = 1'b0;
      req_bus.action = tlg_pkg::ACT_WRITE;
      req_bus.row    = '0;
      req_bus.col    = '0;
      req_bus.alive  = 1'b0;
      rsp_bus.ready  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cell_access();
      test_edge_wrap();
      test_random_traffic(260, 1'b1);
      test_drain_pause();
      test_random_traffic(260, 1'b0);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   pending_responses.size()));

      $display("Ran %0d writes, %0d reads, %0d generation steps, %0d unused-code requests;",
               writes_sent, reads_sent, steps_sent, unused_sent);
      $display("checked %0d responses, %0d mismatches.", responses_checked, mismatches);
      if (mismatches == 0)
         $display("PASS toroidal_life_generation");
      else
         $display("FAIL toroidal_life_generation");
      $finish;
   end

endmodule
